// ----- sv/jpeg_header_scanner_unit_defines.svh -----
// Assertion macros for the checker file of the header scanner.
`ifndef JPEG_HEADER_SCANNER_UNIT_DEFINES_SVH
`define JPEG_HEADER_SCANNER_UNIT_DEFINES_SVH

// Checked only while reset is released.
`define JHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define JHS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/jhs_pkg.sv -----
`default_nettype none

package jhs_pkg;

	// Marker bytes.
	localparam logic [7:0] MarkPrefix = 8'hFF;
	localparam logic [7:0] MarkSof    = 8'hC0;
	localparam logic [7:0] MarkDqt    = 8'hDB;
	localparam logic [7:0] MarkEohHi  = 8'h3F;
	localparam logic [7:0] MarkEohLo  = 8'h00;

	// Table geometry and capture step codes.
	localparam int         TableLen    = 64;
	localparam logic [5:0] TableLast   = 6'd63;
	localparam logic [6:0] TblStepIdle = 7'd0;
	localparam logic [6:0] TblStepArm  = 7'd2;
	localparam logic [6:0] TblFirst    = 7'd5;
	localparam logic [6:0] TblLast     = 7'd68;
	localparam logic [3:0] SzStepIdle  = 4'd0;
	localparam logic [3:0] SzStepArm   = 4'd2;
	localparam logic [3:0] SzHeightHi  = 4'd5;
	localparam logic [3:0] SzHeightLo  = 4'd6;
	localparam logic [3:0] SzWidthHi   = 4'd7;
	localparam logic [3:0] SzWidthLo   = 4'd8;
	localparam logic [10:0] PosMax     = 11'h7FF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic        header_found;
		logic [10:0] header_size;
		logic        size_marker_found;
		logic [7:0]  width_blocks;
		logic [7:0]  height_blocks;
		logic        table_valid;
		logic [5:0]  table_index;
		logic [7:0]  table_value;
		logic        last_result;
	} out_item_t;

	// Per-frame summary handed from the scanner to the result emitter.
	typedef struct packed {
		logic        header_found;
		logic [10:0] header_size;
		logic        size_marker_found;
		logic [7:0]  width_blocks;
		logic [7:0]  height_blocks;
		logic        table_valid;
	} frame_cmd_t;

	typedef struct packed {
		logic       en;
		logic [5:0] addr;
		logic [7:0] data;
	} tbl_wr_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Size in 8-pixel blocks from a big-endian 16-bit dimension, low 8 bits kept.
	function automatic logic [7:0] blocks_of(input logic [7:0] hi, input logic [7:0] lo);
		return {hi[2:0], lo[7:3]};
	endfunction

endpackage

`default_nettype wire

// ----- sv/jpeg_header_scanner_unit.sv -----
// Throughput: one byte per cycle unless the block stalls; each frame gives a burst of 64 results.
// A byte that writes the quantization table stalls while an earlier burst still waits for or reads it.
// Any byte also stalls while two frame summaries wait for their bursts.
// The frame summary passes through the queue and the command register before a burst's first result is registered.
// Reset (arst_n low, asynchronous): frame scan, captures, queue and burst sequencer clear; table contents
// stay undefined until captured.
`default_nettype none

module jpeg_header_scanner_unit import jhs_pkg::*; #(
	parameter int SCAN_LIMIT = 1024
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_stall,
	input  wire in_item_t  byte_item,
	output logic           result_valid,
	input  wire logic      result_stall,
	output out_item_t      result_item
);

	frame_cmd_t cmd_push;
	frame_cmd_t cmd_pop;
	tbl_wr_t    tbl_wr;
	q_stat_t    q_stat;
	logic       push;
	logic       pop;
	logic       busy;
	logic       tbl_busy;

	// The table is in use while a summary waits or a burst runs.
	assign tbl_busy = busy || !q_stat.empty;

	jhs_front #(
		.SCAN_LIMIT(SCAN_LIMIT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item (byte_item),
		.tbl_busy  (tbl_busy),
		.q_stat    (q_stat),
		.push      (push),
		.cmd       (cmd_push),
		.tbl_wr    (tbl_wr)
	);

	jhs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd_push),
		.pop    (pop),
		.cmd_out(cmd_pop),
		.q_stat (q_stat)
	);

	jhs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.tbl_wr      (tbl_wr),
		.cmd         (cmd_pop),
		.q_stat      (q_stat),
		.pop         (pop),
		.busy        (busy),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

endmodule

`default_nettype wire

// ----- sv/jhs_front.sv -----
`default_nettype none

module jhs_front import jhs_pkg::*; #(
	parameter int SCAN_LIMIT = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire in_item_t   byte_item,
	input  wire logic       tbl_busy,
	input  wire q_stat_t    q_stat,
	output logic            push,
	output frame_cmd_t      cmd,
	output tbl_wr_t         tbl_wr
);

	localparam logic [10:0] LimitPos = 11'(SCAN_LIMIT);

	logic [7:0]  prev_q;
	logic [10:0] pos_q;
	logic        active_q;
	logic        seen_q;
	logic [10:0] hlen_q;
	logic [3:0]  sstep_q;
	logic [6:0]  tstep_q;
	logic [7:0]  hold_q;
	logic [7:0]  width_q;
	logic [7:0]  height_q;
	logic        present_q;

	logic [3:0]  sstep_d;
	logic [6:0]  tstep_d;
	logic [7:0]  hold_d;
	logic [7:0]  width_d;
	logic [7:0]  height_d;
	logic        present_d;
	logic        twrite;
	logic        check;
	logic        hit_sof;
	logic        hit_dqt;
	logic        hit_eoh;
	logic        active_n;
	logic [10:0] hlen_n;
	logic        acc;
	logic [7:0]  b;

	assign b = byte_item.data_byte;

	// A table write waits while a result burst runs or still waits to read the table.
	assign twrite     = (tstep_q >= TblFirst) && (tstep_q <= TblLast);
	assign byte_stall = q_stat.full || (tbl_busy && twrite);
	assign acc        = byte_valid && !byte_stall;

	// Size capture steps through the two dimension fields.
	always_comb begin
		hold_d   = hold_q;
		height_d = height_q;
		width_d  = width_q;
		unique case (sstep_q)
			SzHeightHi: hold_d = b;
			SzHeightLo: height_d = blocks_of(hold_q, b);
			SzWidthHi:  hold_d = b;
			SzWidthLo:  width_d = blocks_of(hold_q, b);
			default: ;
		endcase
		if (sstep_q == SzStepIdle) begin
			sstep_d = SzStepIdle;
		end else if (sstep_q >= SzWidthLo) begin
			sstep_d = SzStepIdle;
		end else begin
			sstep_d = sstep_q + 4'd1;
		end
	end

	// Table capture counts through 64 entry bytes.
	always_comb begin
		present_d = present_q;
		if (tstep_q == TblStepIdle) begin
			tstep_d = TblStepIdle;
		end else if (tstep_q >= TblLast) begin
			tstep_d   = TblStepIdle;
			present_d = 1'b1;
		end else begin
			tstep_d = tstep_q + 7'd1;
		end
	end

	assign tbl_wr.en   = acc && twrite;
	assign tbl_wr.addr = 6'(tstep_q - TblFirst);
	assign tbl_wr.data = b;

	// Pair detection inside the scan window.
	assign check    = (pos_q != 11'd0) && (pos_q <= LimitPos) && active_q;
	assign hit_sof  = check && !seen_q && (prev_q == MarkPrefix) && (b == MarkSof);
	assign hit_dqt  = check && (prev_q == MarkPrefix) && (b == MarkDqt);
	assign hit_eoh  = check && (prev_q == MarkEohHi) && (b == MarkEohLo);
	assign active_n = active_q && !hit_eoh;
	assign hlen_n   = hit_eoh ? (pos_q + 11'd1) : hlen_q;

	// Frame summary goes to the queue with the last byte.
	assign push                  = acc && byte_item.frame_end;
	assign cmd.header_found      = !active_n;
	assign cmd.header_size       = active_n ? 11'd0 : hlen_n;
	assign cmd.size_marker_found = seen_q || hit_sof;
	assign cmd.width_blocks      = width_d;
	assign cmd.height_blocks     = height_d;
	assign cmd.table_valid       = present_d;

	// Per-frame state restarts after the last byte; stores persist.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= 8'd0;
			pos_q     <= 11'd0;
			active_q  <= 1'b1;
			seen_q    <= 1'b0;
			hlen_q    <= 11'd0;
			sstep_q   <= SzStepIdle;
			tstep_q   <= TblStepIdle;
			hold_q    <= 8'd0;
			width_q   <= 8'd0;
			height_q  <= 8'd0;
			present_q <= 1'b0;
		end else if (acc) begin
			hold_q    <= hold_d;
			width_q   <= width_d;
			height_q  <= height_d;
			present_q <= present_d;
			if (byte_item.frame_end) begin
				prev_q   <= 8'd0;
				pos_q    <= 11'd0;
				active_q <= 1'b1;
				seen_q   <= 1'b0;
				hlen_q   <= 11'd0;
				sstep_q  <= SzStepIdle;
				tstep_q  <= TblStepIdle;
			end else begin
				prev_q   <= b;
				pos_q    <= (pos_q != PosMax) ? (pos_q + 11'd1) : pos_q;
				active_q <= active_n;
				seen_q   <= seen_q || hit_sof;
				hlen_q   <= hlen_n;
				sstep_q  <= hit_sof ? SzStepArm : sstep_d;
				tstep_q  <= hit_dqt ? TblStepArm : tstep_d;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/jhs_queue.sv -----
`default_nettype none

module jhs_queue import jhs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire frame_cmd_t cmd_in,
	input  wire logic       pop,
	output frame_cmd_t      cmd_out,
	output q_stat_t         q_stat
);

	frame_cmd_t  slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	assign cmd_out      = slot_q[rd_q];
	assign q_stat.empty = (cnt_q == 2'd0);
	assign q_stat.full  = (cnt_q == 2'd2);

	// Two-entry frame summary queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

// ----- sv/jhs_back.sv -----
`default_nettype none

module jhs_back import jhs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tbl_wr_t    tbl_wr,
	input  wire frame_cmd_t cmd,
	input  wire q_stat_t    q_stat,
	output logic            pop,
	output logic            busy,
	output logic            result_valid,
	input  wire logic       result_stall,
	output out_item_t       result_item
);

	logic [7:0]  mem [TableLen];
	logic [7:0]  rdata_q;
	logic        busy_q;
	logic [5:0]  k_q;
	frame_cmd_t  cmd_q;
	out_item_t   meta_q;
	logic        valid_q;
	logic        adv;
	logic        load;

	assign pop  = !busy_q && !q_stat.empty;
	assign busy = busy_q;
	assign adv  = !valid_q || !result_stall;
	assign load = busy_q && adv;

	// Burst sequencer: one table entry per result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= 6'd0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= 6'd0;
			end else if (load) begin
				k_q <= k_q + 6'd1;
				if (k_q == TableLast) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Command and result payload registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
		if (load) begin
			meta_q.header_found      <= cmd_q.header_found;
			meta_q.header_size       <= cmd_q.header_size;
			meta_q.size_marker_found <= cmd_q.size_marker_found;
			meta_q.width_blocks      <= cmd_q.width_blocks;
			meta_q.height_blocks     <= cmd_q.height_blocks;
			meta_q.table_valid       <= cmd_q.table_valid;
			meta_q.table_index       <= k_q;
			meta_q.table_value       <= 8'd0;
			meta_q.last_result       <= (k_q == TableLast);
		end
	end

	// Quantization table: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (tbl_wr.en) begin
			mem[tbl_wr.addr] <= tbl_wr.data;
		end
		if (load) begin
			rdata_q <= mem[k_q];
		end
	end

	always_comb begin
		result_item             = meta_q;
		result_item.table_value = rdata_q;
	end

	assign result_valid = valid_q;

endmodule

`default_nettype wire

// ----- sv/jhs_checker.sv -----
`default_nettype none
`include "jpeg_header_scanner_unit_defines.svh"

module jhs_checker import jhs_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      byte_valid,
	input wire logic      byte_stall,
	input wire in_item_t  byte_item,
	input wire logic      result_valid,
	input wire logic      result_stall,
	input wire out_item_t result_item
);

	// A stalled result stays offered.
	`JHS_ASSERT(a_hold, result_valid && result_stall |=> result_valid, "result dropped under stall")

	// Within a burst the next result follows at once with the next index.
	`JHS_ASSERT(a_next, result_valid && !result_stall && !result_item.last_result |=> result_valid && (result_item.table_index == $past(result_item.table_index) + 6'd1), "burst broken")

	// Header facts do not change inside a burst.
	`JHS_ASSERT(a_facts, result_valid && !result_stall && !result_item.last_result |=> (result_item.header_size == $past(result_item.header_size)) && (result_item.width_blocks == $past(result_item.width_blocks)), "facts changed in burst")

	// A missing header end reports size zero.
	`JHS_ASSERT(a_size, result_valid && !result_item.header_found |-> result_item.header_size == 11'd0, "size without header end")

	// Once reset has been seen at an edge, nothing is offered in the next cycle.
	`JHS_ASSERT_ALWAYS(a_rst, !arst_n |=> !result_valid, "result during reset")

endmodule

bind jpeg_header_scanner_unit jhs_checker u_chk (.*);

`default_nettype wire

// ----- sim/jpeg_header_scanner_unit_tb.sv -----
`timescale 1ns / 1ps

module jpeg_header_scanner_unit_tb;
	import jhs_pkg::*;

	localparam int ScanLimit     = 1024;
	localparam int WatchdogLimit = 4000;
	localparam int TailCycles    = 16;
	localparam int TotalBytes    = 230;
	localparam int SofLen        = 9;
	localparam int DqtLen        = 69;

	// One byte request waiting for the driver, with its pacing flags.
	typedef struct {
		in_item_t item;
		bit       quiet;
		bit       drain;
	} byte_request_t;

	logic      clk;
	logic      arst_n       = 1'b0;
	logic      byte_valid   = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item    = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result_item;

	jpeg_header_scanner_unit #(.SCAN_LIMIT(ScanLimit)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	// Scanner state as the predictor sees it.
	logic [7:0]  prev_byte;
	logic [10:0] byte_pos;
	logic        scanning;
	logic        sof_seen;
	logic [10:0] hdr_len;
	logic [3:0]  size_step;
	logic [6:0]  tbl_step;
	logic [7:0]  dim_hi;
	logic [7:0]  width_q;
	logic [7:0]  height_q;
	logic [7:0]  qtab [TableLen];
	logic        tbl_done;

	byte_request_t pending_requests[$];
	out_item_t     predicted_results[$];

	bit gen_quiet  = 1'b0;
	bit gen_drain  = 1'b0;
	bit byte_busy  = 1'b0;
	bit quiet_now  = 1'b0;
	int gap_left   = 0;
	int stall_left = 0;

	int failures       = 0;
	int results_seen   = 0;
	int bytes_taken    = 0;
	int frames_seen    = 0;
	int found_frames   = 0;
	int sof_frames     = 0;
	int idle_cycles    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Per-frame part of the scanner state goes back to its reset values.
	task automatic frame_restart();
		prev_byte = 8'h00;
		byte_pos  = 11'd0;
		scanning  = 1'b1;
		sof_seen  = 1'b0;
		hdr_len   = 11'd0;
		size_step = SzStepIdle;
		tbl_step  = TblStepIdle;
	endtask

	// Dimension in 8-pixel units, low 8 bits kept.
	function automatic logic [7:0] to_blocks(input logic [7:0] hi, input logic [7:0] lo);
		logic [15:0] dim;
		dim = {hi, lo};
		return dim[10:3];
	endfunction

	// Advance the predicted scanner by one accepted byte; a frame end queues a burst.
	task automatic scan_byte(input in_item_t it);
		logic [7:0]  b;
		logic [10:0] pos;
		logic [6:0]  off;
		out_item_t   r;
		b   = it.data_byte;
		pos = byte_pos;

		// Captures in flight use the byte before any new marker is looked at.
		if (size_step != SzStepIdle) begin
			case (size_step)
				SzHeightHi: dim_hi = b;
				SzHeightLo: height_q = to_blocks(dim_hi, b);
				SzWidthHi: dim_hi = b;
				SzWidthLo: width_q = to_blocks(dim_hi, b);
				default: ;
			endcase
			size_step = (size_step >= SzWidthLo) ? SzStepIdle : size_step + 4'd1;
		end
		if (tbl_step != TblStepIdle) begin
			if (tbl_step >= TblFirst && tbl_step <= TblLast) begin
				off = tbl_step - TblFirst;
				qtab[off[5:0]] = b;
			end
			if (tbl_step >= TblLast) begin
				tbl_done = 1'b1;
				tbl_step = TblStepIdle;
			end else begin
				tbl_step = tbl_step + 7'd1;
			end
		end

		// Pair checks only inside the scan window and before the header end.
		if (pos >= 11'd1 && (int'(pos) - 1) < ScanLimit && scanning) begin
			if (!sof_seen && prev_byte == MarkPrefix && b == MarkSof) begin
				sof_seen  = 1'b1;
				size_step = SzStepArm;
			end
			if (prev_byte == MarkPrefix && b == MarkDqt)
				tbl_step = TblStepArm;
			if (prev_byte == MarkEohHi && b == MarkEohLo) begin
				scanning = 1'b0;
				hdr_len  = pos + 11'd1;
			end
		end

		prev_byte = b;
		if (byte_pos < PosMax)
			byte_pos = byte_pos + 11'd1;

		if (it.frame_end) begin
			for (int k = 0; k < TableLen; k++) begin
				r.header_found      = !scanning;
				r.header_size       = scanning ? 11'd0 : hdr_len;
				r.size_marker_found = sof_seen;
				r.width_blocks      = width_q;
				r.height_blocks     = height_q;
				r.table_valid       = tbl_done;
				r.table_index       = 6'(k);
				r.table_value       = qtab[k];
				r.last_result       = (6'(k) == TableLast);
				predicted_results.push_back(r);
			end
			frames_seen++;
			if (!scanning)
				found_frames++;
			if (sof_seen)
				sof_frames++;
			frame_restart();
		end
	endtask

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit last = 1'b0);
		byte_request_t req;
		req.item.data_byte = b;
		req.item.frame_end = last;
		req.quiet          = gen_quiet;
		req.drain          = gen_drain;
		gen_drain          = 1'b0;
		pending_requests.push_back(req);
	endtask

	// Random filler; with no_eoh set, a 3F is bent so no stray header end appears.
	task automatic push_fill(input int n, input bit no_eoh = 1'b0);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			if (no_eoh && b == MarkEohHi)
				b = 8'h3E;
			push_byte(b);
		end
	endtask

	task automatic push_end();
		push_byte(8'($urandom), 1'b1);
	endtask

	task automatic push_eoh();
		push_byte(MarkEohHi);
		push_byte(MarkEohLo);
	endtask

	// Frame start segment, cut short when cut is below its length.
	task automatic push_sof(input logic [15:0] h, input logic [15:0] w, input int cut = SofLen);
		logic [7:0] seg [SofLen];
		seg = '{MarkPrefix, MarkSof, 8'h00, 8'h11, 8'h08, h[15:8], h[7:0], w[15:8], w[7:0]};
		for (int i = 0; i < cut && i < SofLen; i++)
			push_byte(seg[i]);
	endtask

	// Table segment; the fixed pattern holds both extremes and no marker pair.
	task automatic push_dqt(input bit fixed, input int cut = DqtLen);
		logic [7:0] v;
		int k;
		for (int i = 0; i < cut && i < DqtLen; i++) begin
			k = i - 5;
			if (i == 0)
				v = MarkPrefix;
			else if (i == 1)
				v = MarkDqt;
			else if (i == 3)
				v = 8'h43;
			else if (i < 5)
				v = 8'h00;
			else if (!fixed)
				v = 8'($urandom);
			else if (k == 0)
				v = 8'h00;
			else if (k == TableLen - 1)
				v = 8'hFF;
			else
				v = 8'(k * 4 + 1);
			push_byte(v);
		end
	endtask

	// Byte driver: a request holds until taken, then a gap or the next one.
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (byte_busy) begin
			// Request still waiting for the block to take it.
		end else if (gap_left > 0) begin
			gap_left--;
			byte_valid <= 1'b0;
		end else if (pending_requests.size() != 0 &&
			!(pending_requests[0].drain && predicted_results.size() != 0)) begin
			byte_item  <= pending_requests[0].item;
			byte_valid <= 1'b1;
			quiet_now  = pending_requests[0].quiet;
			gap_left   = quiet_now ? 0 : pick_gap();
			pending_requests.pop_front();
			byte_busy  = 1'b1;
		end else begin
			byte_valid <= 1'b0;
		end
	end

	// Result side back-pressure.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (!quiet_now)
				stall_left = pick_gap();
		end
	end

	// Accepted byte requests feed the predictor.
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) begin
			scan_byte(byte_item);
			byte_busy = 1'b0;
			bytes_taken++;
		end
	end

	// Each accepted result is checked against the oldest prediction.
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Unexpected result: index %0d value %0d last %0d",
						result_item.table_index, result_item.table_value,
						result_item.last_result);
			end else begin
				want = predicted_results.pop_front();
				results_seen++;
				if (result_item.header_found !== want.header_found ||
					result_item.header_size !== want.header_size ||
					result_item.size_marker_found !== want.size_marker_found ||
					result_item.width_blocks !== want.width_blocks ||
					result_item.height_blocks !== want.height_blocks ||
					result_item.table_valid !== want.table_valid ||
					result_item.table_index !== want.table_index ||
					result_item.table_value !== want.table_value ||
					result_item.last_result !== want.last_result) begin
					failures++;
					if (failures <= 10) begin
						$display("Mismatch, expected: found %0d size %0d sof %0d w %0d h %0d tv %0d idx %0d val %0d last %0d",
							want.header_found, want.header_size, want.size_marker_found,
							want.width_blocks, want.height_blocks, want.table_valid,
							want.table_index, want.table_value, want.last_result);
						$display("          actual:   found %0d size %0d sof %0d w %0d h %0d tv %0d idx %0d val %0d last %0d",
							result_item.header_found, result_item.header_size,
							result_item.size_marker_found, result_item.width_blocks,
							result_item.height_blocks, result_item.table_valid,
							result_item.table_index, result_item.table_value,
							result_item.last_result);
					end
				end
			end
		end
	end

	// Watchdog on cycles where neither side moves anything.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WatchdogLimit) begin
				$display("Watchdog: %0d cycles with no transfer", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int kind;
		int ntab;
		frame_restart();
		dim_hi   = 8'h00;
		width_q  = 8'h00;
		height_q = 8'h00;
		tbl_done = 1'b0;

		// First frame fills the whole table before any frame end reads it. A table
		// capture is restarted, and the header end falls inside the new capture.
		push_byte(MarkPrefix);
		push_byte(8'hD8);
		push_sof(16'hFFFF, 16'h0000);
		push_dqt(1'b1, 12);
		push_byte(MarkPrefix);
		push_byte(MarkDqt);
		push_eoh();
		push_fill(TableLen + 1);
		push_end();

		// One-byte frame, sent only after the previous burst has drained.
		gen_drain = 1'b1;
		push_byte(8'hFF, 1'b1);

		// Header end on the very first pair; a frame start after it is ignored.
		gen_quiet = 1'b1;
		push_eoh();
		push_sof(16'h0123, 16'h4567);
		push_end();
		gen_quiet = 1'b0;

		// Only the first frame start marker of a frame is captured.
		push_sof(16'h00F8, 16'h0780);
		push_sof(16'h1234, 16'h5678);
		push_byte(8'h00, 1'b1);

		// Table capture abandoned by the frame end.
		push_dqt(1'b0, 22);
		push_end();

		// Size capture abandoned after the height high byte, then after the height.
		push_sof(16'hABCD, 16'h7FFF, 6);
		push_end();
		push_sof(16'h5A5A, 16'hFFFF, 7);
		push_end();

		// A size capture started right before the header end runs on past it.
		push_byte(MarkPrefix);
		push_byte(MarkSof);
		push_eoh();
		push_fill(6);
		push_end();

		// Random frames: mostly well formed, the rest noise and cut segments.
		while (pending_requests.size() < TotalBytes) begin
			gen_quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				gen_drain = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				if ($urandom_range(0, 1)) begin
					push_byte(MarkPrefix);
					push_byte(8'hD8);
				end
				push_fill($urandom_range(0, 6));
				if ($urandom_range(0, 1))
					push_sof(16'($urandom), 16'($urandom));
				ntab = $urandom_range(0, 9);
				ntab = (ntab < 5) ? 0 : (ntab < 9) ? 1 : 2;
				repeat (ntab)
					push_dqt(1'b0);
				push_fill($urandom_range(0, 8));
				if ($urandom_range(0, 99) < 85)
					push_eoh();
				push_fill($urandom_range(0, 20));
			end else if (kind < 85) begin
				push_fill($urandom_range(0, 30));
			end else if ($urandom_range(0, 1)) begin
				push_fill($urandom_range(0, 3));
				push_sof(16'($urandom), 16'($urandom), $urandom_range(2, SofLen - 1));
			end else begin
				push_fill($urandom_range(0, 3));
				push_dqt(1'b0, $urandom_range(2, DqtLen - 1));
			end
			push_end();
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || byte_busy)
			@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);

		if (predicted_results.size() != 0)
			failures++;
		$display("Run covered %0d frames in %0d bytes, %0d results checked.",
			frames_seen, bytes_taken, results_seen);
		$display("Frames with header end: %0d, with frame start marker: %0d, failures: %0d.",
			found_frames, sof_frames, failures);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
